// ===== design/rlt_pkg.sv =====
// ---------------------------------------------------------------------------
// Registration lifetime table - shared definitions
// Action and result codes, the table entry layout and the id generator step.
// ---------------------------------------------------------------------------
package rlt_pkg;

   // request actions
   localparam logic [2:0] ACT_REGISTER = 3'd0;
   localparam logic [2:0] ACT_UPDATE   = 3'd1;
   localparam logic [2:0] ACT_QUERY    = 3'd2;
   localparam logic [2:0] ACT_TICK     = 3'd3;
   localparam logic [2:0] ACT_CLEAR    = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_QUERY   = 2'd1;
   localparam logic [1:0] KIND_DONE    = 2'd2;
   localparam logic [1:0] KIND_FULL    = 2'd3;

   localparam logic [15:0] INFINITE_LIFETIME = 16'hffff;
   localparam logic [15:0] THRESHOLD_RESET   = 16'd5;
   localparam logic [31:0] LFSR_TOGGLE       = 32'h8020_0003;
   localparam logic [31:0] LFSR_SEED         = 32'd1;

   // one table entry
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] coa;
      logic [31:0] id;
      logic [15:0] original;
      logic [15:0] remaining;
   } entry_type;

   // Galois step, right shift; the all-zero state is forced back to one
   function automatic logic [31:0] lfsr_step(input logic [31:0] cur);
      logic [31:0] nxt;
      nxt = {1'b0, cur[31:1]};
      if (cur[0]) begin
         nxt = nxt ^ LFSR_TOGGLE;
      end
      if (nxt == 32'd0) begin
         nxt = LFSR_SEED;
      end
      return nxt;
   endfunction

endpackage

// ===== design/rlt_table.sv =====
// ---------------------------------------------------------------------------
// Registration lifetime table - entry memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rlt_table #(
   parameter int TABLE_DEPTH = 16,
   parameter int IDX_W       = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  rlt_pkg::entry_type    wr_data,
   input  logic [IDX_W-1:0]      rd_addr,
   output rlt_pkg::entry_type    rd_data
);
   import rlt_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rlt_idgen.sv =====
// ---------------------------------------------------------------------------
// Registration lifetime table - identification generator
// 32-bit LFSR; the offered id is the next state minus one.
// ---------------------------------------------------------------------------
module rlt_idgen (
   input  logic        clock,
   input  logic        reset,
   input  logic        draw,
   output logic [31:0] next_id
);
   import rlt_pkg::*;

   logic [31:0] lfsr_ff;
   logic [31:0] lfsr_in;
   logic [31:0] lfsr_nxt;

   // next state and the id it yields
   always_comb begin
      lfsr_nxt = lfsr_step(lfsr_ff);
      lfsr_in  = draw ? lfsr_nxt : lfsr_ff;
      next_id  = lfsr_nxt - 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
      end else begin
         lfsr_ff <= lfsr_in;
      end
   end

endmodule

// ===== design/rlt_seq.sv =====
// ---------------------------------------------------------------------------
// Registration lifetime table - sequencer
// Walks the packed entries once per request through one compare/update unit,
// then finishes the request and drives the result register.
// ---------------------------------------------------------------------------
module rlt_seq #(
   parameter int TABLE_DEPTH = 16,
   parameter int IDX_W       = 4,
   parameter int CNT_W       = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_action,
   input  logic [31:0]           req_agent_address,
   input  logic [31:0]           req_care_of_address,
   input  logic [15:0]           req_lifetime,
   input  logic [31:0]           req_reply_id,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [1:0]            rsp_kind,
   output logic [31:0]           rsp_dest_address,
   output logic [31:0]           rsp_request_coa,
   output logic [15:0]           rsp_request_lifetime,
   output logic [31:0]           rsp_request_id,
   output logic                  rsp_found,
   output logic                  rsp_last,
   // threshold
   input  logic [15:0]           renew_threshold,
   // table
   output logic                  wr_en,
   output logic [IDX_W-1:0]      wr_addr,
   output rlt_pkg::entry_type    wr_data,
   output logic [IDX_W-1:0]      rd_addr,
   input  rlt_pkg::entry_type    rd_data,
   // id generator
   output logic                  draw,
   input  logic [31:0]           next_id
);
   import rlt_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   logic [1:0]       state_ff,     state_in;
   logic [IDX_W-1:0] idx_ff,       idx_in;
   logic [CNT_W-1:0] fill_ff,      fill_in;
   logic [2:0]       act_ff,       act_in;
   logic [31:0]      agent_ff,     agent_in;
   logic [31:0]      coa_ff,       coa_in;
   logic [15:0]      life_ff,      life_in;
   logic [31:0]      rid_ff,       rid_in;
   logic             match_ff,     match_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             found_ff,     found_in;

   logic             rsp_valid_ff;
   logic [1:0]       kind_ff;
   logic [31:0]      dest_ff;
   logic [31:0]      rcoa_ff;
   logic [15:0]      rlife_ff;
   logic [31:0]      rid_out_ff;
   logic             found_out_ff;
   logic             last_ff;

   logic             out_free;
   logic             emit;
   logic [1:0]       o_kind;
   logic [31:0]      o_dest;
   logic [31:0]      o_coa;
   logic [15:0]      o_life;
   logic [31:0]      o_id;
   logic             o_found;
   logic             o_last;

   logic [CNT_W-1:0] idx_next;
   logic             scan_last;
   logic             advance;
   logic [15:0]      dec;
   logic [15:0]      diff;
   logic [15:0]      upd;
   logic             req_accept;

   assign req_accept = req_valid && (state_ff == ST_IDLE);
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // sequencer and shared entry unit
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      act_in       = act_ff;
      agent_in     = agent_ff;
      coa_in       = coa_ff;
      life_in      = life_ff;
      rid_in       = rid_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      found_in     = found_ff;

      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      draw    = 1'b0;

      emit    = 1'b0;
      o_kind  = KIND_DONE;
      o_dest  = 32'd0;
      o_coa   = 32'd0;
      o_life  = 16'd0;
      o_id    = 32'd0;
      o_found = 1'b0;
      o_last  = 1'b1;

      idx_next  = CNT_W'(idx_ff) + CNT_W'(1);
      scan_last = (idx_next == fill_ff);
      advance   = 1'b1;
      dec       = rd_data.remaining - 16'd1;
      diff      = rd_data.original - life_ff;
      upd       = rd_data.remaining - diff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               act_in   = req_action;
               agent_in = req_agent_address;
               coa_in   = req_care_of_address;
               life_in  = req_lifetime;
               rid_in   = req_reply_id;
               idx_in   = '0;
               match_in = 1'b0;
               found_in = 1'b0;
               if (fill_ff != '0 && req_action <= ACT_TICK) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            // rd_data holds the entry at idx_ff
            unique case (act_ff)
               ACT_REGISTER: begin
                  if (rd_data.dest == agent_ff && rd_data.coa == coa_ff) begin
                     match_in     = 1'b1;
                     match_idx_in = idx_ff;
                  end
               end
               ACT_UPDATE: begin
                  if (rd_data.id == rid_ff) begin
                     wr_en             = 1'b1;
                     wr_data.remaining = upd;
                  end
               end
               ACT_QUERY: begin
                  if (rd_data.coa == coa_ff) begin
                     found_in = 1'b1;
                  end
               end
               ACT_TICK: begin
                  if (rd_data.original != INFINITE_LIFETIME) begin
                     if (dec <= renew_threshold) begin
                        // renewal needs the result register
                        if (out_free) begin
                           draw              = 1'b1;
                           wr_en             = 1'b1;
                           wr_data.id        = next_id;
                           wr_data.remaining = rd_data.original;
                           emit              = 1'b1;
                           o_kind            = KIND_REQUEST;
                           o_dest            = rd_data.dest;
                           o_coa             = rd_data.coa;
                           o_life            = rd_data.original;
                           o_id              = next_id;
                           o_last            = 1'b0;
                        end else begin
                           advance = 1'b0;
                        end
                     end else begin
                        wr_en             = 1'b1;
                        wr_data.remaining = dec;
                     end
                  end
               end
               default: begin
               end
            endcase

            if (!advance) begin
               rd_addr = idx_ff;
            end else if (scan_last) begin
               state_in = ST_FINISH;
            end else begin
               idx_in  = IDX_W'(idx_next);
               rd_addr = IDX_W'(idx_next);
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               unique case (act_ff)
                  ACT_REGISTER: begin
                     if (!match_ff && fill_ff == FULL_COUNT) begin
                        o_kind = KIND_FULL;
                     end else begin
                        draw          = 1'b1;
                        wr_en         = 1'b1;
                        wr_data.dest      = agent_ff;
                        wr_data.coa       = coa_ff;
                        wr_data.id        = next_id;
                        wr_data.original  = life_ff;
                        wr_data.remaining = life_ff;
                        if (match_ff) begin
                           wr_addr = match_idx_ff;
                        end else begin
                           wr_addr = IDX_W'(fill_ff);
                           fill_in = fill_ff + CNT_W'(1);
                        end
                        o_kind = KIND_REQUEST;
                        o_dest = agent_ff;
                        o_coa  = coa_ff;
                        o_life = life_ff;
                        o_id   = next_id;
                     end
                  end
                  ACT_QUERY: begin
                     o_kind  = KIND_QUERY;
                     o_found = found_ff;
                  end
                  ACT_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request fields and scan progress
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      act_ff       <= act_in;
      agent_ff     <= agent_in;
      coa_ff       <= coa_in;
      life_ff      <= life_in;
      rid_ff       <= rid_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      found_ff     <= found_in;
   end

   // result register, loaded on each transfer slot
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff      <= o_kind;
         dest_ff      <= o_dest;
         rcoa_ff      <= o_coa;
         rlife_ff     <= o_life;
         rid_out_ff   <= o_id;
         found_out_ff <= o_found;
         last_ff      <= o_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_dest_address     = dest_ff;
   assign rsp_request_coa      = rcoa_ff;
   assign rsp_request_lifetime = rlife_ff;
   assign rsp_request_id       = rid_out_ff;
   assign rsp_found            = found_out_ff;
   assign rsp_last             = last_ff;

endmodule

// ===== design/registration_lifetime_table_top.sv =====
// ---------------------------------------------------------------------------
// Registration lifetime table - top level
// Table of pending registrations with lifetimes, ids and renewal on tick.
// ---------------------------------------------------------------------------
// Usage:
//  req_*  : one request per transfer (register, reply update, query, tick,
//           clear). req_stall stays high while a request is being worked on.
//  rsp_*  : one or more results per request; rsp_last marks the final one.
//           A tick gives one request result per renewed entry, then done.
//  csr_*  : write of renew_threshold; csr_ready is always high. Write only
//           while no request is in flight.
// Sequence: a request that walks N entries (register, update, query and tick
//  walk the filled entries; clear, unused codes and an empty table walk none)
//  passes each of them in turn through the shared compare/update unit, then
//  takes a finish step that loads its final result. The input reopens once
//  that finish step is done, so no new request is taken before the last
//  one is through. The entry walk through the single table read port sets
//  the request spacing. One request is in flight at a time.
// Stalls: when rsp_stall holds a result, the walk pauses at the next entry
//  that has to produce a result, and resumes once the register frees up.
// Reset: synchronous; empties the table, reloads the id LFSR with one and
//  sets the threshold to 5. No clearing pass is needed.
// ---------------------------------------------------------------------------
module registration_lifetime_table_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_agent_address,
   input  logic [31:0] req_care_of_address,
   input  logic [15:0] req_lifetime,
   input  logic [31:0] req_reply_id,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_dest_address,
   output logic [31:0] rsp_request_coa,
   output logic [15:0] rsp_request_lifetime,
   output logic [31:0] rsp_request_id,
   output logic        rsp_found,
   output logic        rsp_last,
   // threshold write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);
   import rlt_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic [15:0]      threshold_ff;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   logic [IDX_W-1:0] rd_addr;
   entry_type        rd_data;
   logic             draw;
   logic [31:0]      next_id;

   // threshold register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_data;
      end
   end

   rlt_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rlt_idgen u_idgen (
      .clock   (clock),
      .reset   (reset),
      .draw    (draw),
      .next_id (next_id)
   );

   rlt_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_seq (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_agent_address    (req_agent_address),
      .req_care_of_address  (req_care_of_address),
      .req_lifetime         (req_lifetime),
      .req_reply_id         (req_reply_id),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_dest_address     (rsp_dest_address),
      .rsp_request_coa      (rsp_request_coa),
      .rsp_request_lifetime (rsp_request_lifetime),
      .rsp_request_id       (rsp_request_id),
      .rsp_found            (rsp_found),
      .rsp_last             (rsp_last),
      .renew_threshold      (threshold_ff),
      .wr_en                (wr_en),
      .wr_addr              (wr_addr),
      .wr_data              (wr_data),
      .rd_addr              (rd_addr),
      .rd_data              (rd_data),
      .draw                 (draw),
      .next_id              (next_id)
   );

endmodule

// ===== design/rlt_check.sv =====
// ---------------------------------------------------------------------------
// Registration lifetime table - port checker
// Assertions on the top level's ports, attached by bind.
// ---------------------------------------------------------------------------
module rlt_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_dest_address,
   input logic [31:0] rsp_request_id,
   input logic        rsp_found,
   input logic        rsp_last
);
   import rlt_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_request_id) && $stable(rsp_last))
      else $error("stalled result changed");

   // one request in flight: an accepted request closes the input
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after a transfer");

   // only request results carry request fields
   a_request_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_REQUEST |->
         rsp_dest_address == 32'd0 && rsp_request_id == 32'd0)
      else $error("request fields set on a non-request result");

   // found only on a query answer
   a_found_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_kind == KIND_QUERY)
      else $error("found set outside a query answer");

   // query, done and full results end their request
   a_final_kinds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_REQUEST |-> rsp_last)
      else $error("non-request result not marked last");

endmodule

bind registration_lifetime_table_top rlt_check u_rlt_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_dest_address (rsp_dest_address),
   .rsp_request_id   (rsp_request_id),
   .rsp_found        (rsp_found),
   .rsp_last         (rsp_last)
);

// ===== test/lifetime_table_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Registration lifetime table - result checker
// Watches the request, result and threshold channels, keeps its own copy of
// the table, id generator and threshold, and compares every result transfer
// field by field with the oldest predicted one.
// ---------------------------------------------------------------------------
module lifetime_table_checker #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_agent_address,
   input  logic [31:0] req_care_of_address,
   input  logic [15:0] req_lifetime,
   input  logic [31:0] req_reply_id,
   // result channel
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [31:0] rsp_dest_address,
   input  logic [31:0] rsp_request_coa,
   input  logic [15:0] rsp_request_lifetime,
   input  logic [31:0] rsp_request_id,
   input  logic        rsp_found,
   input  logic        rsp_last,
   // threshold write
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   // status for the stimulus side
   output int          pending,
   output int          error_count,
   output int          item_count,
   output int          result_count,
   output int          full_count,
   output logic [31:0] last_request_id
);
   import rlt_pkg::*;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] dest;
      logic [31:0] coa;
      logic [15:0] lifetime;
      logic [31:0] id;
      logic        found;
      logic        last;
   } table_result_type;

   table_result_type due_results[$];

   // predicted table state
   logic        slot_used [TABLE_DEPTH];
   entry_type   slot [TABLE_DEPTH];
   int          used_slots;
   logic [31:0] id_state;
   logic [15:0] renew_level;

   int errs, items, results, fulls;

   // one step of the id generator; the id is the new state minus one
   function automatic logic [31:0] draw_ident();
      logic [31:0] s;
      s = id_state >> 1;
      if (id_state[0]) begin
         s = s ^ LFSR_TOGGLE;
      end
      if (s == 32'd0) begin
         s = LFSR_SEED;
      end
      id_state = s;
      return s - 32'd1;
   endfunction

   function automatic table_result_type make_result(input logic [1:0] kind,
                                                    input logic [31:0] dest,
                                                    input logic [31:0] coa,
                                                    input logic [15:0] lifetime,
                                                    input logic [31:0] id,
                                                    input logic found,
                                                    input logic last);
      table_result_type r;
      r.kind     = kind;
      r.dest     = dest;
      r.coa      = coa;
      r.lifetime = lifetime;
      r.id       = id;
      r.found    = found;
      r.last     = last;
      return r;
   endfunction

   // append one predicted result at the tail
   task automatic queue_result(input table_result_type r);
      due_results.insert(due_results.size(), r);
   endtask

   // apply one request to the predicted table and queue its results
   task automatic predict_request(input logic [2:0] act, input logic [31:0] agent,
                                  input logic [31:0] coa, input logic [15:0] life,
                                  input logic [31:0] rid);
      logic        hit;
      logic [31:0] ident;
      logic [15:0] gap;
      hit = 1'b0;
      case (act)
         ACT_REGISTER: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i] && slot[i].coa == coa && slot[i].dest == agent) begin
                  hit = 1'b1;
               end
            end
            if (!hit && used_slots >= TABLE_DEPTH) begin
               // full table: nothing changes, id generator included
               queue_result(make_result(KIND_FULL, '0, '0, '0, '0, 1'b0, 1'b1));
               fulls++;
            end else begin
               ident = draw_ident();
               if (hit) begin
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (slot_used[i] && slot[i].coa == coa && slot[i].dest == agent) begin
                        slot[i].id        = ident;
                        slot[i].original  = life;
                        slot[i].remaining = life;
                     end
                  end
               end else begin
                  slot_used[used_slots]      = 1'b1;
                  slot[used_slots].dest      = agent;
                  slot[used_slots].coa       = coa;
                  slot[used_slots].id        = ident;
                  slot[used_slots].original  = life;
                  slot[used_slots].remaining = life;
                  used_slots++;
               end
               queue_result(make_result(KIND_REQUEST, agent, coa, life, ident,
                                        1'b0, 1'b1));
            end
         end
         ACT_UPDATE: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i] && slot[i].id == rid) begin
                  gap = slot[i].original - life;
                  slot[i].remaining = slot[i].remaining - gap;
               end
            end
         end
         ACT_QUERY: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i] && slot[i].coa == coa) begin
                  hit = 1'b1;
               end
            end
            queue_result(make_result(KIND_QUERY, '0, '0, '0, '0, hit, 1'b1));
         end
         ACT_TICK: begin
            // count down in slot order, renewing at or below the threshold
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_used[i] && slot[i].original != INFINITE_LIFETIME) begin
                  slot[i].remaining = slot[i].remaining - 16'd1;
                  if (slot[i].remaining <= renew_level) begin
                     ident = draw_ident();
                     slot[i].id        = ident;
                     slot[i].remaining = slot[i].original;
                     queue_result(make_result(KIND_REQUEST, slot[i].dest,
                                              slot[i].coa, slot[i].original,
                                              ident, 1'b0, 1'b0));
                  end
               end
            end
         end
         ACT_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               slot_used[i] = 1'b0;
            end
            used_slots = 0;
         end
         default: begin
         end
      endcase
      if (act != ACT_REGISTER && act != ACT_QUERY) begin
         queue_result(make_result(KIND_DONE, '0, '0, '0, '0, 1'b0, 1'b1));
      end
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: result %0d %s mismatch, expected %h, actual %h",
                  $time, results, label, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : watch
      table_result_type want;
      if (reset) begin
         due_results.delete();
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            slot_used[i] = 1'b0;
         end
         used_slots  = 0;
         id_state    = LFSR_SEED;
         renew_level = THRESHOLD_RESET;
         last_request_id <= '0;
      end else begin
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d id %h",
                        $time, rsp_kind, rsp_request_id);
               errs++;
            end else begin
               want = due_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("dest_address", want.dest, rsp_dest_address);
               check_field("request_coa", want.coa, rsp_request_coa);
               check_field("request_lifetime", 32'(want.lifetime),
                           32'(rsp_request_lifetime));
               check_field("request_id", want.id, rsp_request_id);
               check_field("found", 32'(want.found), 32'(rsp_found));
               check_field("last", 32'(want.last), 32'(rsp_last));
            end
            if (rsp_kind == KIND_REQUEST) begin
               last_request_id <= rsp_request_id;
            end
         end
         // threshold write
         if (csr_valid && csr_ready) begin
            renew_level = csr_data;
         end
         // request transfer
         if (req_valid && !req_stall) begin
            items++;
            predict_request(req_action, req_agent_address, req_care_of_address,
                            req_lifetime, req_reply_id);
         end
      end
      pending      <= due_results.size();
      error_count  <= errs;
      item_count   <= items;
      result_count <= results;
      full_count   <= fulls;
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Registration lifetime table - testbench top
// Drives directed and random requests and threshold writes through four
// idle/stall phases; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;
   import rlt_pkg::*;

   localparam int          CYCLE_LIMIT = 200000;
   localparam logic [31:0] AGENT_BASE  = 32'h0a00_0001;
   localparam logic [31:0] COA_BASE    = 32'hc0a8_0001;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = ACT_QUERY;
   logic [31:0] req_agent_address = '0;
   logic [31:0] req_care_of_address = '0;
   logic [15:0] req_lifetime = '0;
   logic [31:0] req_reply_id = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_dest_address;
   logic [31:0] rsp_request_coa;
   logic [15:0] rsp_request_lifetime;
   logic [31:0] rsp_request_id;
   logic        rsp_found;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   int          pending, error_count, item_count, result_count, full_count;
   logic [31:0] last_request_id;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          cycle_count = 0;

   registration_lifetime_table_top uut (.*);

   lifetime_table_checker table_check (.*);

   always #5 clock = ~clock;

   // receiver stalls
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** registration_lifetime_table_top: FAILED **");
         $finish;
      end
   end

   // one request transfer, with random idle cycles ahead of it
   task automatic send_req(input logic [2:0] act, input logic [31:0] agent,
                           input logic [31:0] coa, input logic [15:0] life,
                           input logic [31:0] rid);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_action          <= act;
      req_agent_address   <= agent;
      req_care_of_address <= coa;
      req_lifetime        <= life;
      req_reply_id        <= rid;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every predicted result has arrived, then let the block drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [15:0] level);
      csr_valid <= 1'b1;
      csr_data  <= level;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // mostly keys from a small pool so entries get replaced, renewed and matched
   task automatic send_random();
      int          pick;
      logic [2:0]  act;
      logic [31:0] agent, coa, rid;
      logic [15:0] life;
      pick = $urandom_range(99);
      if (pick < 36) act = ACT_REGISTER;
      else if (pick < 66) act = ACT_TICK;
      else if (pick < 78) act = ACT_UPDATE;
      else if (pick < 90) act = ACT_QUERY;
      else if (pick < 95) act = ACT_CLEAR;
      else act = ACT_CLEAR + 3'($urandom_range(1, 3));
      agent = ($urandom_range(99) < 85) ? AGENT_BASE + $urandom_range(4) : $urandom;
      coa   = ($urandom_range(99) < 85) ? COA_BASE + $urandom_range(4) : $urandom;
      pick = $urandom_range(99);
      if (pick < 50) life = 16'($urandom_range(1, 12));
      else if (pick < 65) life = INFINITE_LIFETIME;
      else if (pick < 75) life = '0;
      else life = 16'($urandom);
      rid = ($urandom_range(99) < 70) ? last_request_id : $urandom;
      send_req(act, agent, coa, life, rid);
   endtask

   task automatic run_phase(input int idle, input int stall, input logic [15:0] level,
                            input int count);
      idle_pct  = idle;
      stall_pct = stall;
      settle();
      write_threshold(level);
      for (int n = 0; n < count; n++) begin
         // one mid-phase pause with everything drained
         if (n == count / 2) begin
            settle();
         end
         send_random();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, replace, infinite and zero lifetimes, extremes
      send_req(ACT_QUERY, '0, COA_BASE, '0, '0);
      send_req(ACT_TICK, '0, '0, '0, '0);
      send_req(ACT_UPDATE, '0, '0, '0, 32'hffff_ffff);
      send_req(ACT_REGISTER, AGENT_BASE, COA_BASE, 16'd8, '0);
      send_req(ACT_REGISTER, AGENT_BASE, COA_BASE, 16'd20, '0);
      send_req(ACT_REGISTER, AGENT_BASE, COA_BASE + 1, INFINITE_LIFETIME, '0);
      send_req(ACT_REGISTER, AGENT_BASE + 1, COA_BASE, '0, '0);
      send_req(ACT_REGISTER, 32'hffff_ffff, 32'hffff_ffff, 16'd6, 32'hffff_ffff);
      send_req(ACT_REGISTER, '0, '0, 16'd7, '0);
      settle();
      // reply update matching the id just handed out
      send_req(ACT_UPDATE, '0, '0, '0, last_request_id);
      send_req(ACT_QUERY, '0, COA_BASE, '0, '0);
      send_req(ACT_QUERY, '0, 32'hffff_ffff, '0, '0);
      send_req(ACT_TICK, '0, '0, '0, '0);
      for (int a = ACT_CLEAR + 1; a < 8; a++) begin
         send_req(3'(a), 32'hffff_ffff, 32'hffff_ffff, INFINITE_LIFETIME, '0);
      end
      // fill the table; the last one finds it full
      for (int k = 0; k < 12; k++) begin
         send_req(ACT_REGISTER, 32'h0b00_0000 + k, COA_BASE + k, 16'd30, '0);
      end
      // replacing an existing key still works when full
      send_req(ACT_REGISTER, AGENT_BASE, COA_BASE, 16'd9, '0);
      send_req(ACT_TICK, '0, '0, '0, '0);
      send_req(ACT_CLEAR, '0, '0, '0, '0);
      send_req(ACT_QUERY, '0, COA_BASE, '0, '0);

      // random phases, each with its own threshold
      run_phase(0, 0, 16'd0, 22);
      run_phase(72, 0, 16'hffff, 22);
      run_phase(0, 72, 16'($urandom_range(1, 10)), 22);
      run_phase(19, 19, THRESHOLD_RESET, 22);
      settle();

      $display("Covered %0d requests and %0d results over four idle/stall phases,",
               item_count, result_count);
      $display("thresholds 0, 65535, small and 5; %0d registers met a full table.",
               full_count);
      if (error_count == 0 && pending == 0) begin
         $display("** registration_lifetime_table_top: PASSED **");
      end else begin
         $display("** registration_lifetime_table_top: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/rlt_pkg.sv
design/rlt_table.sv
design/rlt_idgen.sv
design/rlt_seq.sv
design/registration_lifetime_table_top.sv
design/rlt_check.sv
test/lifetime_table_checker.sv
test/tb_top.sv
